// ----- rtl/core/vch_pkg.sv -----
// Shared types and constants for the FIFO vertex cache hit counter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package vch_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int CFG_W = 6;
  localparam int VTX_W = 32;
  localparam int TOT_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
  localparam logic [TOT_W-1:0] TOT_MAX   = '1;

  // front -> hit queue
  typedef struct packed {
    logic push;
    logic hit;
  } hq_wr_t;

  // hit queue -> front / back
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
  } hq_stat_t;

  typedef struct packed {
    logic             was_hit;
    logic [TOT_W-1:0] hit_total;
    logic [TOT_W-1:0] miss_total;
  } res_t;

  function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
    return (v == TOT_MAX) ? v : v + TOT_W'(1);
  endfunction

endpackage

// ----- rtl/core/vch_front.sv -----
// Front end: size register, entry store, parallel lookup and FIFO replacement.
// Depends on vch_pkg.
`timescale 1ns / 1ps

module vch_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [vch_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      push_i,
  input  logic [vch_pkg::VTX_W-1:0] vertex_index_i,
  input  vch_pkg::hq_stat_t         hq_stat_i,
  output logic                      full_o,
  output vch_pkg::hq_wr_t           hq_wr_o
);
  import vch_pkg::*;

  logic [CFG_W-1:0] cfg_q;
  logic [VTX_W-1:0] entry_q [MAX_ENTRIES];
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] wptr_q, wptr_d;

  logic [CNT_W-1:0] size, valid_n, nxt;
  logic [IDX_W-1:0] pos;
  logic             hit, accept;

  assign full_o = hq_stat_i.full;
  assign accept = push_i && !hq_stat_i.full;

  always_comb begin
    if (cfg_q == '0) begin
      size = CNT_W'(1);
    end else if (int'(cfg_q) > MAX_ENTRIES) begin
      size = CNT_W'(MAX_ENTRIES);
    end else begin
      size = CNT_W'(cfg_q);
    end
    valid_n = (fill_q < size) ? fill_q : size;
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if ((CNT_W'(i) < valid_n) && (entry_q[i] == vertex_index_i)) hit = 1'b1;
    end
  end

  // a pointer left past a shrunk size restarts at entry zero
  always_comb begin
    pos    = (CNT_W'(wptr_q) < size) ? wptr_q : '0;
    nxt    = CNT_W'(pos) + CNT_W'(1);
    wptr_d = wptr_q;
    fill_d = fill_q;
    if (accept && !hit) begin
      wptr_d = (nxt >= size) ? '0 : nxt[IDX_W-1:0];
      if (fill_q < size) fill_d = fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CFG_RESET;
      fill_q <= '0;
      wptr_q <= '0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_data_i;
      fill_q <= fill_d;
      wptr_q <= wptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !hit) entry_q[pos] <= vertex_index_i;
  end

  assign hq_wr_o.push = accept;
  assign hq_wr_o.hit  = hit;

endmodule

// ----- rtl/core/vch_hitq.sv -----
// Two-entry queue of hit flags between the lookup front end and the counters.
// Depends on vch_pkg.
`timescale 1ns / 1ps

module vch_hitq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vch_pkg::hq_wr_t   hq_wr_i,
  input  logic              pop_i,
  output vch_pkg::hq_stat_t hq_stat_o
);
  import vch_pkg::*;

  logic [1:0] slot_q;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign hq_stat_o.full  = (cnt_q == 2'd2);
  assign hq_stat_o.empty = (cnt_q == 2'd0);
  assign hq_stat_o.hit   = slot_q[rd_q];

  assign do_push = hq_wr_i.push && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= hq_wr_i.hit;
  end

endmodule

// ----- rtl/core/vch_back.sv -----
// Back end: saturating hit and miss counters and the two-entry result queue.
// Depends on vch_pkg.
`timescale 1ns / 1ps

module vch_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vch_pkg::hq_stat_t hq_stat_i,
  output logic              hq_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output vch_pkg::res_t     res_o
);
  import vch_pkg::*;

  logic [TOT_W-1:0] hit_q, hit_d, miss_q, miss_d;
  res_t             oq_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             take, do_pop;

  assign take   = !hq_stat_i.empty && (cnt_q != 2'd2);
  assign do_pop = pop_i && (cnt_q != 2'd0);

  assign hq_pop_o = take;
  assign empty_o  = (cnt_q == 2'd0);
  assign res_o    = oq_q[rd_q];

  always_comb begin
    hit_d  = hit_q;
    miss_d = miss_q;
    if (take) begin
      if (hq_stat_i.hit) hit_d = sat_inc(hit_q);
      else               miss_d = sat_inc(miss_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= '0;
      miss_q <= '0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      hit_q  <= hit_d;
      miss_q <= miss_d;
      if (take)   wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(take) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      oq_q[wr_q].was_hit    <= hq_stat_i.hit;
      oq_q[wr_q].hit_total  <= hit_d;
      oq_q[wr_q].miss_total <= miss_d;
    end
  end

endmodule

// ----- rtl/core/fifo_vertex_cache_hit_counter.sv -----
// FIFO vertex cache hit counter. An item's hit flag is registered in the hit queue, then
// its totals in the result queue. Throughput: one item per cycle unless a queue is full,
// set by the front end's combinational compare of all entries and in-place replacement.
// Reset (async, active low) clears fill count, write pointer, counters and queues;
// the size register returns to 16. Entry contents are not cleared.
`timescale 1ns / 1ps

module fifo_vertex_cache_hit_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [vch_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic [vch_pkg::VTX_W-1:0] vertex_index_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      was_hit_o,
  output logic [vch_pkg::TOT_W-1:0] hit_total_o,
  output logic [vch_pkg::TOT_W-1:0] miss_total_o
);
  import vch_pkg::*;

  hq_wr_t   hq_wr;
  hq_stat_t hq_stat;
  logic     hq_pop;
  res_t     res;

  vch_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push),
    .vertex_index_i (vertex_index_i),
    .hq_stat_i      (hq_stat),
    .full_o         (full),
    .hq_wr_o        (hq_wr)
  );

  vch_hitq u_hitq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hq_wr_i   (hq_wr),
    .pop_i     (hq_pop),
    .hq_stat_o (hq_stat)
  );

  vch_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hq_stat_i (hq_stat),
    .hq_pop_o  (hq_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign was_hit_o    = res.was_hit;
  assign hit_total_o  = res.hit_total;
  assign miss_total_o = res.miss_total;

endmodule

// ----- rtl/core/vch_checker.sv -----
// Port-level checks for fifo_vertex_cache_hit_counter, attached by bind.
// Depends on vch_pkg.
`timescale 1ns / 1ps

module vch_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      empty,
  input logic                      pop,
  input logic                      was_hit_o,
  input logic [vch_pkg::TOT_W-1:0] hit_total_o,
  input logic [vch_pkg::TOT_W-1:0] miss_total_o
);
  import vch_pkg::*;

  // totals of the last item taken from the result side
  logic [TOT_W-1:0] last_hit_q, last_miss_q;
  logic             take;

  assign take = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hit_q  <= '0;
      last_miss_q <= '0;
    end else if (take) begin
      last_hit_q  <= hit_total_o;
      last_miss_q <= miss_total_o;
    end
  end

  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result side not empty during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hit_total_o) && $stable(miss_total_o)
                          && $stable(was_hit_o)))
    else $error("waiting result changed before it was taken");

  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && was_hit_o) |-> (hit_total_o == sat_inc(last_hit_q)
                             && miss_total_o == last_miss_q))
    else $error("hit item does not advance hit total by one");

  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !was_hit_o) |-> (miss_total_o == sat_inc(last_miss_q)
                              && hit_total_o == last_hit_q))
    else $error("miss item does not advance miss total by one");

endmodule

bind fifo_vertex_cache_hit_counter vch_checker u_vch_checker (.*);

// ----- tb/tb_fifo_vertex_cache_hit_counter.sv -----
// Self-checking testbench for the FIFO vertex cache hit counter.
// Depends on vch_pkg and fifo_vertex_cache_hit_counter; cache state is tracked here.
`timescale 1ns / 1ps

module tb_fifo_vertex_cache_hit_counter;
  import vch_pkg::*;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b1;
  logic             cfg_we_i       = 1'b0;
  logic [CFG_W-1:0] cfg_data_i     = '0;
  logic             push           = 1'b0;
  logic             full;
  logic [VTX_W-1:0] vertex_index_i = '0;
  logic             empty;
  logic             pop            = 1'b0;
  logic             was_hit_o;
  logic [TOT_W-1:0] hit_total_o;
  logic [TOT_W-1:0] miss_total_o;

  fifo_vertex_cache_hit_counter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .vertex_index_i(vertex_index_i),
    .empty         (empty),
    .pop           (pop),
    .was_hit_o     (was_hit_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Cache state as the block should hold it
  logic [VTX_W-1:0] cache_tag [MAX_ENTRIES];
  logic [CFG_W-1:0] size_reg    = CFG_RESET;
  logic [5:0]       fill_level  = '0;
  logic [4:0]       wr_ptr      = '0;
  logic [TOT_W-1:0] hits_seen   = '0;
  logic [TOT_W-1:0] misses_seen = '0;

  res_t lookup_results_due [$];
  int   fail_count    = 0;
  int   vertices_sent = 0;
  int   size_writes   = 0;
  int   send_calm     = 0;
  int   pop_calm      = 0;
  logic [VTX_W-1:0] window_base = 32'h0000_1000;

  function automatic int unsigned active_entries();
    if (size_reg == '0) return 1;
    if (size_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return 32'(size_reg);
  endfunction

  function automatic int unsigned compared_entries();
    int unsigned size;
    size = active_entries();
    return (fill_level < size) ? fill_level : size;
  endfunction

  function automatic logic is_cached(input logic [VTX_W-1:0] v);
    int unsigned n;
    n = compared_entries();
    for (int unsigned i = 0; i < n; i++)
      if (cache_tag[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t predict_lookup(input logic [VTX_W-1:0] v);
    res_t        r;
    int unsigned size;
    int unsigned pos;
    size = active_entries();
    r.was_hit = is_cached(v);
    if (r.was_hit) begin
      if (hits_seen != TOT_MAX) hits_seen = hits_seen + 1'b1;
    end else begin
      if (misses_seen != TOT_MAX) misses_seen = misses_seen + 1'b1;
      // pointer left past a shrunk size restarts at entry 0
      pos = (wr_ptr < size) ? wr_ptr : 0;
      cache_tag[pos] = v;
      pos++;
      if (pos >= size) pos = 0;
      wr_ptr = pos[4:0];
      if (fill_level < size) fill_level = fill_level + 1'b1;
    end
    r.hit_total  = hits_seen;
    r.miss_total = misses_seen;
    return r;
  endfunction

  function automatic logic [VTX_W-1:0] fresh_vertex();
    logic [VTX_W-1:0] v;
    v = $urandom;
    while (is_cached(v)) v = $urandom;
    return v;
  endfunction

  // Index stream: a drifting local window (reuse), cached entries, and noise
  function automatic logic [VTX_W-1:0] next_stream_vertex();
    int unsigned roll;
    int unsigned valid;
    roll  = $urandom_range(0, 9);
    valid = compared_entries();
    if (roll < 4) begin
      if ($urandom_range(0, 7) == 0) window_base = window_base + $urandom_range(1, 40);
      return window_base + $urandom_range(0, 2 * active_entries());
    end
    if (roll < 7 && valid != 0) return cache_tag[$urandom_range(0, valid - 1)];
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [TOT_W-1:0] got,
                                 input logic [TOT_W-1:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
  endtask

  // Called right after a rising edge; returns at the edge that took the item
  task automatic send_vertex(input logic [VTX_W-1:0] v);
    int   gap;
    res_t due;
    if (send_calm == 0 && $urandom_range(0, 15) == 0) send_calm = 40;
    gap = (send_calm > 0) ? 0 : $urandom_range(0, 9);
    if (send_calm > 0) send_calm--;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    vertex_index_i <= v;
    do @(posedge clk_i); while (full !== 1'b0);
    due = predict_lookup(v);
    lookup_results_due = {lookup_results_due, due};
    vertices_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_cache_size(input logic [CFG_W-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = val;
    size_writes++;
  endtask

  // Reset size 16: hits, misses, extreme and alternating indices.
  // Fewer than 16 misses keep the pointer in step with the fill count.
  task automatic test_basic_hits();
    send_vertex(32'h0000_0000);
    send_vertex(32'h0000_0000);
    send_vertex(32'hFFFF_FFFF);
    send_vertex(32'hFFFF_FFFF);
    send_vertex(32'h0000_0001);
    send_vertex(32'h7FFF_FFFF);
    send_vertex(32'h8000_0000);
    send_vertex(32'hAAAA_AAAA);
    send_vertex(32'h5555_5555);
    send_vertex(32'h0000_0000);
    send_vertex(32'h8000_0000);
  endtask

  // Grow to full depth while the cache is still filling, then fill the remaining entries
  task automatic test_fill_full_depth();
    set_cache_size(CFG_W'(MAX_ENTRIES));
    while (fill_level < MAX_ENTRIES) send_vertex(fresh_vertex());
  endtask

  task automatic test_eviction_and_size_limits();
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    // full cache: a new index evicts the oldest entry (index 0)
    send_vertex(fresh_vertex());
    send_vertex(32'h0000_0000);
    // size 0 behaves as a single entry
    set_cache_size(CFG_W'(0));
    a = fresh_vertex();
    b = a ^ 32'h0000_0100;
    send_vertex(a);
    send_vertex(a);
    send_vertex(b);
    send_vertex(a);
    // size above the built depth behaves as full depth
    set_cache_size(CFG_W'(63));
    send_vertex(a);
    send_vertex(32'hFFFF_FFFF);
  endtask

  // Resize between phases (the pointer is often left past a shrunk size)
  task automatic test_resize_random();
    logic [CFG_W-1:0] plan [14];
    plan = '{6'd1, 6'd2, 6'd33, 6'd8, 6'd31, 6'd0, 6'd16, 6'd5, 6'd63, 6'd32, 6'd3, 6'd24,
             6'd0, 6'd0};
    plan[12] = $urandom_range(0, 63);
    plan[13] = $urandom_range(0, 63);
    foreach (plan[p]) begin
      set_cache_size(plan[p]);
      repeat (133) send_vertex(next_stream_vertex());
    end
  endtask

  initial begin : result_checker
    int   stall;
    res_t want;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (pop_calm == 0 && $urandom_range(0, 15) == 0) pop_calm = 40;
      stall = (pop_calm > 0) ? 0 : $urandom_range(0, 9);
      if (pop_calm > 0) pop_calm--;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      if (lookup_results_due.size() == 0) begin
        report_mismatch("result with no item pending", hit_total_o, '0);
      end else begin
        want = lookup_results_due.pop_front();
        if (was_hit_o !== want.was_hit)
          report_mismatch("was_hit", TOT_W'(was_hit_o), TOT_W'(want.was_hit));
        if (hit_total_o !== want.hit_total)
          report_mismatch("hit_total", hit_total_o, want.hit_total);
        if (miss_total_o !== want.miss_total)
          report_mismatch("miss_total", miss_total_o, want.miss_total);
      end
    end
  end

  initial begin
    // falling reset at time zero so the asynchronous reset takes effect at once
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_hits();
    test_fill_full_depth();
    test_eviction_and_size_limits();
    test_resize_random();
    drain();
    repeat (10) @(posedge clk_i);
    if (lookup_results_due.size() != 0)
      report_mismatch("results never returned", lookup_results_due.size(), '0);
    $display("Ran %0d vertex indices (%0d hits, %0d misses) across %0d size settings",
             vertices_sent, hits_seen, misses_seen, size_writes);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- fifo_vertex_cache_hit_counter.f -----
rtl/core/vch_pkg.sv
rtl/core/vch_front.sv
rtl/core/vch_hitq.sv
rtl/core/vch_back.sv
rtl/core/fifo_vertex_cache_hit_counter.sv
rtl/core/vch_checker.sv
tb/tb_fifo_vertex_cache_hit_counter.sv
